FILE: src/srv_pkg.sv
// Shared types and constants for the servo ramp core.
// Used by srv_ctrl, srv_dpath and servo_ramp_with_damped_overshoot_core.
// No dependencies.
package srv_pkg;

	// input item kinds carried on s_tuser
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_COLOR = 1'b1;

	// colour codes
	localparam logic COLOR_GREEN = 1'b0;
	localparam logic COLOR_RED   = 1'b1;

	// configuration register indexes
	localparam logic [7:0] REG_START_ANGLE = 8'd0;
	localparam logic [7:0] REG_STOP_ANGLE  = 8'd1;
	localparam logic [7:0] REG_OVERSHOOT   = 8'd2;
	localparam logic [7:0] REG_STEP_INTVL  = 8'd3;
	localparam logic [7:0] REG_ANGLE_LOW   = 8'd4;
	localparam logic [7:0] REG_ANGLE_HIGH  = 8'd5;
	localparam logic [7:0] REG_PULSE_LOW   = 8'd6;
	localparam logic [7:0] REG_PULSE_HIGH  = 8'd7;

	// register reset values
	localparam logic [7:0]  RST_START_ANGLE = 8'd70;
	localparam logic [7:0]  RST_STOP_ANGLE  = 8'd100;
	localparam logic [5:0]  RST_OVERSHOOT   = 6'd5;
	localparam logic [19:0] RST_STEP_INTVL  = 20'd50000;
	localparam logic [7:0]  RST_ANGLE_LOW   = 8'd0;
	localparam logic [7:0]  RST_ANGLE_HIGH  = 8'd180;
	localparam logic [11:0] RST_PULSE_LOW   = 12'd150;
	localparam logic [11:0] RST_PULSE_HIGH  = 12'd600;

	// saturating tick counter ceiling
	localparam logic [20:0] TICK_MAX = 21'h1F_FFFF;

	// dividend magnitude width and number of divider iterations
	localparam int unsigned DVD_W     = 23;
	localparam logic [4:0]  DIV_STEPS = 5'd23;

	// largest pulse width
	localparam logic [11:0] PULSE_MAX = 12'hFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_EMIT_MAP,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic apply;    // take the accepted item into the servo state
		logic mul;      // register the mapping product and divisor
		logic prep;     // load the divider with magnitudes
		logic div;      // one restoring divider iteration
		logic emit_map; // load output register with a mapped write
		logic emit;     // load output register without a write
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic move;     // the offered item steps the servo
		logic div_last; // the current divider iteration is the last
	} dp_stat_t;

endpackage

FILE: src/srv_dpath.sv
// Datapath of the servo ramp core: config registers, servo state,
// mapping multiply, serial divider and output register. Depends on srv_pkg.
module srv_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic                item_cmd,
	input  logic                item_color,
	input  srv_pkg::ctrl_cmd_t  cmd,
	output srv_pkg::dp_stat_t   stat,
	output logic                out_wv,
	output logic [11:0]         out_pulse,
	output logic [8:0]          out_pos,
	output logic                out_color,
	output logic                out_settled
);
	import srv_pkg::*;

	// configuration registers
	logic [7:0]  start_angle_q, stop_angle_q, angle_low_q, angle_high_q;
	logic [5:0]  overshoot_q;
	logic [19:0] step_intvl_q;
	logic [11:0] pulse_low_q, pulse_high_q;

	// servo state
	logic signed [9:0] angle_q;
	logic [7:0]        goal_q;
	logic signed [6:0] offset_q;
	logic              first_q;
	logic [20:0]       tick_q;
	logic              color_q;

	// step evaluation
	logic [20:0]       tick_inc;
	logic              step;
	logic signed [9:0] target;
	logic              move;
	logic signed [9:0] angle_t;
	logic signed [6:0] off_shrunk;
	logic              shrink;

	// mapping
	logic signed [10:0] am;
	logic signed [12:0] pd;
	logic signed [23:0] prod_s1;
	logic signed [8:0]  den_s1;
	logic [23:0]        num_abs;
	logic [8:0]         den_abs;
	logic [DVD_W-1:0]   dvd_q;
	logic [7:0]         rem_q;
	logic [7:0]         den_mag_q;
	logic               neg_q;
	logic               zero_den_q;
	logic [4:0]         cnt_q;
	logic [8:0]         rem_sh;
	logic               ge;
	logic [8:0]         rem_nx;
	logic signed [24:0] quo_s;
	logic signed [24:0] pulse_v;
	logic [11:0]        pulse_clamped;

	// output fields from state
	logic [8:0] pos_sat;
	logic       settled;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= RST_START_ANGLE;
			stop_angle_q  <= RST_STOP_ANGLE;
			overshoot_q   <= RST_OVERSHOOT;
			step_intvl_q  <= RST_STEP_INTVL;
			angle_low_q   <= RST_ANGLE_LOW;
			angle_high_q  <= RST_ANGLE_HIGH;
			pulse_low_q   <= RST_PULSE_LOW;
			pulse_high_q  <= RST_PULSE_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_data[7:0];
				REG_STOP_ANGLE:  stop_angle_q  <= cfg_data[7:0];
				REG_OVERSHOOT:   overshoot_q   <= cfg_data[5:0];
				REG_STEP_INTVL:  step_intvl_q  <= cfg_data;
				REG_ANGLE_LOW:   angle_low_q   <= cfg_data[7:0];
				REG_ANGLE_HIGH:  angle_high_q  <= cfg_data[7:0];
				REG_PULSE_LOW:   pulse_low_q   <= cfg_data[11:0];
				REG_PULSE_HIGH:  pulse_high_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// tick handling and one-degree step toward goal plus offset
	always_comb begin
		tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 21'd1;
		step     = tick_inc > {1'b0, step_intvl_q};
		target   = $signed({2'b00, goal_q}) + $signed({{3{offset_q[6]}}, offset_q});
		move     = step && (angle_q != target);
		if (!move)
			angle_t = angle_q;
		else if (target > angle_q)
			angle_t = angle_q + 10'sd1;
		else
			angle_t = angle_q - 10'sd1;
		shrink     = step && (offset_q != 7'sd0) && (angle_t == target);
		off_shrunk = offset_q[6] ? -(offset_q + 7'sd1) : -(offset_q - 7'sd1);
	end

	assign stat.move = (item_cmd == CMD_TICK) && move;

	// servo state update on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			goal_q   <= '0;
			offset_q <= '0;
			first_q  <= 1'b1;
			tick_q   <= '0;
			color_q  <= COLOR_RED;
		end else if (cmd.apply) begin
			if (item_cmd == CMD_COLOR) begin
				color_q <= item_color;
				tick_q  <= '0;
				first_q <= 1'b0;
				if (item_color == COLOR_RED) begin
					goal_q   <= stop_angle_q;
					angle_q  <= first_q ? $signed({2'b00, stop_angle_q})
					                    : $signed({2'b00, start_angle_q});
					offset_q <= $signed({1'b0, overshoot_q});
				end else begin
					goal_q   <= start_angle_q;
					angle_q  <= first_q ? $signed({2'b00, start_angle_q})
					                    : $signed({2'b00, stop_angle_q});
					offset_q <= -$signed({1'b0, overshoot_q});
				end
			end else begin
				tick_q  <= step ? 21'd0 : tick_inc;
				angle_q <= angle_t;
				if (shrink)
					offset_q <= off_shrunk;
			end
		end
	end

	// mapping product and divisor
	assign am = $signed({angle_q[9], angle_q}) - $signed({3'b000, angle_low_q});
	assign pd = $signed({1'b0, pulse_high_q}) - $signed({1'b0, pulse_low_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= am * pd;
			den_s1  <= $signed({1'b0, angle_high_q}) - $signed({1'b0, angle_low_q});
		end
	end

	assign num_abs = prod_s1[23] ? 24'(-prod_s1) : 24'(prod_s1);
	assign den_abs = den_s1[8] ? 9'(-den_s1) : 9'(den_s1);

	// restoring divider, one quotient bit per beat of cnt_q
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, den_mag_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_mag_q} : rem_sh;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			dvd_q      <= num_abs[DVD_W-1:0];
			rem_q      <= '0;
			den_mag_q  <= den_abs[7:0];
			neg_q      <= prod_s1[23] ^ den_s1[8];
			zero_den_q <= (den_s1 == 9'sd0);
		end else if (cmd.div) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= rem_nx[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.prep)
			cnt_q <= DIV_STEPS;
		else if (cmd.div)
			cnt_q <= cnt_q - 5'd1;
	end

	assign stat.div_last = (cnt_q == 5'd1);

	// signed quotient, offset and clamp
	always_comb begin
		quo_s = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
		if (zero_den_q)
			pulse_v = $signed({13'd0, pulse_low_q});
		else
			pulse_v = quo_s + $signed({13'd0, pulse_low_q});
		if (pulse_v < 25'sd0)
			pulse_clamped = '0;
		else if (pulse_v > $signed({13'd0, PULSE_MAX}))
			pulse_clamped = PULSE_MAX;
		else
			pulse_clamped = pulse_v[11:0];
	end

	// reported position and settled flag
	always_comb begin
		if (angle_q > 10'sd255)
			pos_sat = 9'd255;
		else if (angle_q < -10'sd256)
			pos_sat = 9'h100;
		else
			pos_sat = angle_q[8:0];
		settled = (offset_q == 7'sd0) && (angle_q == $signed({2'b00, goal_q}));
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.emit_map) begin
			out_wv      <= cmd.emit_map;
			out_pulse   <= cmd.emit_map ? pulse_clamped : 12'd0;
			out_pos     <= pos_sat;
			out_color   <= color_q;
			out_settled <= settled;
		end
	end

endmodule

FILE: src/srv_ctrl.sv
// Controller of the servo ramp core: sequences accept, multiply,
// divide and emit, and owns the output valid flag. Depends on srv_pkg.
module srv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  srv_pkg::dp_stat_t  stat,
	output srv_pkg::ctrl_cmd_t cmd
);
	import srv_pkg::*;

	state_t state_q, state_nx;
	logic   m_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept) state_nx = stat.move ? ST_MUL : ST_EMIT;
			ST_MUL:      state_nx = ST_PREP;
			ST_PREP:     state_nx = ST_DIV;
			ST_DIV:      if (stat.div_last) state_nx = ST_EMIT_MAP;
			ST_EMIT_MAP: state_nx = ST_IDLE;
			ST_EMIT:     state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.apply    = accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div      = (state_q == ST_DIV);
		cmd.emit_map = (state_q == ST_EMIT_MAP);
		cmd.emit     = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// output slot: filled by an emit, drained by a beat
			if (cmd.emit || cmd.emit_map)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

endmodule

FILE: src/servo_ramp_with_damped_overshoot_core.sv
// Channel  | direction | contents
// ---------+-----------+---------------------------------------------------
// s_*      | in        | tuser: cmd; tdata: target_color, zero padded
// m_*      | out       | tuser: write_valid; tdata: pulse_width .. settled
// cfg_*    | in        | register index and write data, always ready
//
// Sequencing: a command, or a tick that does not move the servo, goes from
// accept to emit; a tick that moves it goes through accept, multiply,
// divider load, 23 restoring divider iterations and emit, the divider
// giving one quotient bit per cycle. One item is in flight at a time; the
// next beat is taken once the output register is empty or being drained.
// Reset is asynchronous and loads the register defaults; a stalled
// m_tready holds the result.
// Top level of the servo ramp core. Depends on srv_pkg, srv_ctrl, srv_dpath.
module servo_ramp_with_damped_overshoot_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] cmd
	input  logic [7:0]  s_tdata,   // [0] target_color, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // [0] write_valid
	output logic [23:0] m_tdata,   // [11:0] pulse_width, [20:12] position,
	                               // [21] shown_color, [22] settled, [23] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import srv_pkg::*;

	ctrl_cmd_t   cmd;
	dp_stat_t    stat;
	logic        out_wv;
	logic [11:0] out_pulse;
	logic [8:0]  out_pos;
	logic        out_color;
	logic        out_settled;

	assign cfg_ready = 1'b1;

	srv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srv_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_cmd    (s_tuser),
		.item_color  (s_tdata[0]),
		.cmd         (cmd),
		.stat        (stat),
		.out_wv      (out_wv),
		.out_pulse   (out_pulse),
		.out_pos     (out_pos),
		.out_color   (out_color),
		.out_settled (out_settled)
	);

	// result beat packing
	assign m_tuser = out_wv;
	assign m_tdata = {1'b0, out_settled, out_color, out_pos, out_pulse};

endmodule
